FILE: hw/rtl/edit_distance_engine_macros.svh
// Assertion macros for the edit distance engine.
`ifndef EDIT_DISTANCE_ENGINE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define EDD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EDD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define EDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EDD_ASSERT(label, clk, rst, prop, msg)
`define EDD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define EDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/edd_pkg.sv
// Types and codes shared by the edit distance engine.
`default_nettype none
package edd_pkg;

  localparam logic [1:0] KIND_REF    = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  localparam int DIST_W = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/edit_distance_engine.sv
// Levenshtein distance: a reference byte is stored as it is taken; a finish may wait on an output stall.
// Query byte: sweeps entries 0..n of the cost row memory for a stored reference of n bytes (at most
// MAX_LEN), one entry per cycle; no new input is taken until the sweep ends.
// After a finish beat the engine enters S_FIN and loads the distance into the output register once it is free.
// Synchronous reset clears lengths, overflow flag and handshake state; memories are not
// cleared, the row is seeded by the first query byte of each pair.
`default_nettype none
`include "edit_distance_engine_macros.svh"
module edit_distance_engine
  import edd_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] symbol
  input  wire logic [1:0] s_tuser,   // [1:0] kind
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [6:0] distance, [7] zero
  output logic [0:0]      m_tuser    // [0] overflow
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam logic [LW-1:0] MAX_CNT = LW'(MAX_LEN);
  localparam logic [LW-1:0] ONE = LW'(1);

  logic [7:0]    ref_mem [MAX_LEN];
  logic [LW-1:0] row_mem [MAX_LEN+1];

  state_t state, state_next;

  logic [LW-1:0] ref_len, query_len;
  logic          ovf;
  logic [7:0]    sym;
  logic          seed;
  logic [LW-1:0] rd_j, p_j;
  logic          rd_go, p_valid;
  logic [LW-1:0] diag, left;
  logic [7:0]    ref_q;
  logic [LW-1:0] row_q;

  logic          in_beat, out_free;
  logic          take_ref, take_query, take_fin, drop_ovf, load_out;
  logic [LW-1:0] row_raddr;
  logic [AW-1:0] ref_raddr;
  logic [LW-1:0] up, cost, m2, m3;
  logic          last_cell;
  logic [LW-1:0] dist_src;
  logic [LW+DIST_W-1:0] dist_ext;

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    take_ref   = 1'b0;
    take_query = 1'b0;
    take_fin   = 1'b0;
    drop_ovf   = 1'b0;
    if (in_beat) begin
      case (s_tuser)
        KIND_REF: begin
          if (query_len == '0) begin
            if (ref_len >= MAX_CNT) drop_ovf = 1'b1;
            else take_ref = 1'b1;
          end
        end
        KIND_QUERY: begin
          if (query_len >= MAX_CNT) drop_ovf = 1'b1;
          else take_query = 1'b1;
        end
        KIND_FINISH: take_fin = 1'b1;
        default: ;
      endcase
    end
  end

  // DP cell: the seeded row reads as 0..n on the first query byte
  always_comb begin
    up   = seed ? p_j : row_q;
    m2   = (left < up) ? left : up;
    m3   = (m2 < diag) ? m2 : diag;
    if (p_j == '0) cost = up + ONE;
    else if (ref_q == sym) cost = diag;
    else cost = m3 + ONE;
    last_cell = p_valid && (p_j == ref_len);
  end

  assign load_out = (state == S_FIN) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take_query) state_next = S_SWEEP;
        else if (take_fin) state_next = S_FIN;
      end
      S_SWEEP: if (last_cell) state_next = S_IDLE;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign row_raddr = (state == S_SWEEP) ? rd_j : ref_len;
  assign ref_raddr = AW'(rd_j - ONE);

  always_ff @(posedge clk) begin
    row_q <= row_mem[row_raddr];
    ref_q <= ref_mem[ref_raddr];
    if (take_ref) ref_mem[ref_len[AW-1:0]] <= s_tdata;
    if (p_valid) row_mem[p_j] <= cost;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_len   <= '0;
      query_len <= '0;
      ovf       <= 1'b0;
      rd_go     <= 1'b0;
      p_valid   <= 1'b0;
    end else begin
      if (take_ref) ref_len <= ref_len + ONE;
      if (drop_ovf) ovf <= 1'b1;
      if (take_query) begin
        query_len <= query_len + ONE;
        rd_go     <= 1'b1;
      end else if (rd_go && rd_j == ref_len) begin
        rd_go <= 1'b0;
      end
      p_valid <= (state == S_SWEEP) && rd_go;
      if (load_out) begin
        ref_len   <= '0;
        query_len <= '0;
        ovf       <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_query) begin
      sym  <= s_tdata;
      seed <= (query_len == '0);
      rd_j <= '0;
    end else if (state == S_SWEEP && rd_go && rd_j != ref_len) begin
      rd_j <= rd_j + ONE;
    end
    if (state == S_SWEEP && rd_go) p_j <= rd_j;
    if (p_valid) begin
      diag <= up;
      left <= cost;
    end
  end

  assign dist_src = (query_len == '0) ? ref_len : row_q;
  assign dist_ext = {{DIST_W{1'b0}}, dist_src};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, dist_ext[DIST_W-1:0]};
      m_tuser <= ovf;
    end
  end

  `EDD_ASSERT_IMP(a_write_in_sweep, clk, rst, p_valid, state == S_SWEEP, "row write outside sweep")
  `EDD_ASSERT_IMP(a_cell_in_row, clk, rst, p_valid, p_j <= ref_len, "row index past reference")
  `EDD_ASSERT(a_len_bound, clk, rst, (ref_len <= MAX_CNT) && (query_len <= MAX_CNT), "length overrun")
  `EDD_ASSERT_NEXT(a_fin_loads, clk, rst, load_out, m_tvalid && query_len == '0 && ref_len == '0, "finish did not emit")
  `EDD_ASSERT_IMP(a_sweep_ends, clk, rst, last_cell, !rd_go, "reads still issued at last cell")

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for edit_distance_engine: row-sweep predictor, stream stimulus, result checker.
`default_nettype none
module tb;
  import edd_pkg::*;

  localparam int MAX_LEN = 64;
  localparam int LIMIT = 1_000_000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] symbol
  logic [1:0] s_tuser;   // [1:0] kind
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [6:0] distance, [7] zero
  logic [0:0] m_tuser;   // [0] overflow

  edit_distance_engine #(.MAX_LEN(MAX_LEN)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // Shadow copy of the engine state
  logic [7:0]        ref_store [MAX_LEN];
  logic [DIST_W-1:0] cost_row [MAX_LEN+1];
  int                ref_len;
  int                qry_len;
  logic              ovf_seen;

  result_t pending_results[$];
  result_t head_result;
  int      mismatch_count;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_left;
  int      cycle_count;

  function automatic logic [DIST_W-1:0] min3(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b,
                                            logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // Apply one accepted beat to the shadow state; queue a result on finish.
  function automatic void update_distance(logic [1:0] kind, logic [7:0] sym);
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] up;
    result_t r;
    case (kind)
      KIND_REF: begin
        if (qry_len == 0) begin
          if (ref_len >= MAX_LEN) ovf_seen = 1'b1;
          else begin
            ref_store[ref_len] = sym;
            ref_len++;
          end
        end
      end
      KIND_QUERY: begin
        if (qry_len >= MAX_LEN) ovf_seen = 1'b1;
        else begin
          if (qry_len == 0)
            for (int j = 0; j <= ref_len; j++) cost_row[j] = DIST_W'(j);
          diag = cost_row[0];
          cost_row[0] = diag + 1'b1;
          for (int j = 1; j <= ref_len; j++) begin
            up = cost_row[j];
            cost_row[j] = (ref_store[j-1] == sym) ? diag
                                                  : min3(cost_row[j-1], up, diag) + 1'b1;
            diag = up;
          end
          qry_len++;
        end
      end
      KIND_FINISH: begin
        r.distance = (qry_len == 0) ? DIST_W'(ref_len) : cost_row[ref_len];
        r.overflow = ovf_seen;
        pending_results.push_back(r);
        ref_len = 0;
        qry_len = 0;
        ovf_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [7:0] sym);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= sym;
    do @(posedge clk); while (!s_tready);
    update_distance(kind, sym);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_symbol(bit narrow);
    return narrow ? 8'h61 + 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
  endfunction

  // Mostly short strings; now and then a long one, sometimes past the limit
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(9, MAX_LEN + 2);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_pair(input int ref_n, input int qry_n, input bit narrow, inout int sent);
    for (int i = 0; i < ref_n; i++) send_item(KIND_REF, pick_symbol(narrow));
    for (int i = 0; i < qry_n; i++) send_item(KIND_QUERY, pick_symbol(narrow));
    send_item(KIND_FINISH, pick_symbol(0));
    sent += ref_n + qry_n + 1;
  endtask

  task automatic test_directed();
    send_item(KIND_FINISH, 8'hFF);       // both empty
    send_item(KIND_REF, 8'h00);
    send_item(KIND_REF, 8'hFF);
    send_item(KIND_FINISH, 8'h00);       // empty query
    send_item(KIND_QUERY, 8'hFF);
    send_item(KIND_QUERY, 8'h00);
    send_item(KIND_QUERY, 8'h5A);
    send_item(KIND_FINISH, 8'hA5);       // empty reference
    send_item(KIND_REF, "k");
    send_item(KIND_REF, "i");
    send_item(KIND_REF, "t");
    send_item(KIND_QUERY, "s");
    send_item(KIND_QUERY, "i");
    send_item(KIND_REF, 8'h11);          // dropped, query already started
    send_item(KIND_UNUSED, 8'hAA);       // ignored kind
    send_item(KIND_QUERY, "t");
    send_item(KIND_QUERY, "t");
    send_item(KIND_FINISH, 8'h00);
    send_item(KIND_REF, 8'h7E);
    send_item(KIND_QUERY, 8'h7E);
    send_item(KIND_FINISH, 8'h00);       // exact match
    wait_results_done();
  endtask

  task automatic test_overflow();
    // reference one byte too long
    for (int i = 0; i <= MAX_LEN; i++) send_item(KIND_REF, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 3; i++) send_item(KIND_QUERY, 8'($urandom_range(0, 255)));
    send_item(KIND_FINISH, 8'h00);
    // full reference, query one byte too long, no matches: largest distance
    for (int i = 0; i < MAX_LEN; i++) send_item(KIND_REF, 8'h00);
    for (int i = 0; i <= MAX_LEN; i++) send_item(KIND_QUERY, 8'hFF);
    send_item(KIND_FINISH, 8'h00);
    // full-length identical strings
    for (int i = 0; i < MAX_LEN; i++) send_item(KIND_REF, 8'(i * 3));
    for (int i = 0; i < MAX_LEN; i++) send_item(KIND_QUERY, 8'(i * 3));
    send_item(KIND_FINISH, 8'h00);
    wait_results_done();
  endtask

  task automatic test_random(input int count);
    int sent;
    int r;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 85) send_pair(pick_length(), pick_length(), 1'($urandom_range(1)), sent);
      else if (r < 91) begin
        send_item(KIND_UNUSED, pick_symbol(0));
        sent++;
      end else if (r < 96) begin
        send_item(KIND_REF, pick_symbol(1));
        send_item(KIND_QUERY, pick_symbol(1));
        send_item(KIND_REF, pick_symbol(0));
        send_item(KIND_FINISH, pick_symbol(0));
        sent += 4;
      end else begin
        send_item(KIND_FINISH, pick_symbol(0));
        sent++;
      end
    end
    wait_results_done();
  endtask

  // Receiver holds off long enough for the output to back up into the input
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 300;
    for (int i = 0; i < 6; i++) begin
      send_item(KIND_REF, pick_symbol(0));
      send_item(KIND_QUERY, pick_symbol(0));
      send_item(KIND_FINISH, pick_symbol(0));
    end
    wait_results_done();
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: distance %0d overflow %0d", m_tdata[6:0], m_tuser[0]);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (m_tdata[6:0] !== head_result.distance) begin
          $error("distance: expected %0d, got %0d", head_result.distance, m_tdata[6:0]);
          mismatch_count++;
        end
        if (m_tuser[0] !== head_result.overflow) begin
          $error("overflow: expected %0d, got %0d", head_result.overflow, m_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = KIND_REF;
    m_tready = 1'b0;
    ref_len = 0;
    qry_len = 0;
    ovf_seen = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_overflow();
    test_backpressure();
    send_idle_pct = 0;  stall_pct = 0;  test_random(185);
    send_idle_pct = 59; stall_pct = 0;  test_random(185);
    send_idle_pct = 0;  stall_pct = 59; test_random(185);
    send_idle_pct = 31; stall_pct = 31; test_random(185);

    wait_results_done();
    repeat (MAX_LEN + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

FILE: edit_distance_engine.f
+incdir+hw/rtl
hw/rtl/edd_pkg.sv
hw/rtl/edit_distance_engine.sv
test/tb.sv
